@@ rtl/mfde_pkg.sv @@
// ----------------------------------------------------------------------------
// mfde_pkg
// Shared constants, font tables and helpers for the framebuffer draw engine.
// ----------------------------------------------------------------------------
package mfde_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 32;
  localparam int ROW_BYTES     = (SCREEN_WIDTH + 7) / 8;
  localparam int STORE_BYTES   = SCREEN_HEIGHT * ROW_BYTES;
  localparam int XW            = $clog2(SCREEN_WIDTH);
  localparam int YW            = $clog2(SCREEN_HEIGHT);
  localparam int BW            = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int AW            = $clog2(STORE_BYTES);
  localparam int CW            = 12;  // working coordinate width, signed

  localparam int FONT_GLYPHS = 37;
  localparam int SPACE_INDEX = 36;
  localparam int PCT_DOTS    = 13;

  // command kinds
  localparam logic [2:0] KIND_PLOT  = 3'd0;
  localparam logic [2:0] KIND_FILL  = 3'd1;
  localparam logic [2:0] KIND_GLYPH = 3'd2;
  localparam logic [2:0] KIND_CLEAR = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  // configuration register indexes
  localparam logic CFG_MIRROR_H = 1'b0;
  localparam logic CFG_MIRROR_V = 1'b1;

  localparam logic [7:0] CODE_PERCENT = 8'h25;

  // column coded, bit 0 is the top row
  localparam logic [7:0] FONT_ROM [FONT_GLYPHS][5] = '{
    '{8'h3e, 8'h51, 8'h49, 8'h45, 8'h3e}, '{8'h00, 8'h42, 8'h7f, 8'h40, 8'h00},
    '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4b, 8'h31},
    '{8'h18, 8'h14, 8'h12, 8'h7f, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
    '{8'h3c, 8'h4a, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1e},
    '{8'h7e, 8'h11, 8'h11, 8'h11, 8'h7e}, '{8'h7f, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h3e, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7f, 8'h41, 8'h41, 8'h22, 8'h1c},
    '{8'h7f, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7f, 8'h09, 8'h09, 8'h09, 8'h01},
    '{8'h3e, 8'h41, 8'h49, 8'h49, 8'h7a}, '{8'h7f, 8'h08, 8'h08, 8'h08, 8'h7f},
    '{8'h00, 8'h41, 8'h7f, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3f, 8'h01},
    '{8'h7f, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7f, 8'h40, 8'h40, 8'h40, 8'h40},
    '{8'h7f, 8'h02, 8'h0c, 8'h02, 8'h7f}, '{8'h7f, 8'h04, 8'h08, 8'h10, 8'h7f},
    '{8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e}, '{8'h7f, 8'h09, 8'h09, 8'h09, 8'h06},
    '{8'h3e, 8'h41, 8'h51, 8'h21, 8'h5e}, '{8'h7f, 8'h09, 8'h19, 8'h29, 8'h46},
    '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7f, 8'h01, 8'h01},
    '{8'h3f, 8'h40, 8'h40, 8'h40, 8'h3f}, '{8'h1f, 8'h20, 8'h40, 8'h20, 8'h1f},
    '{8'h3f, 8'h40, 8'h38, 8'h40, 8'h3f}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [2:0] PCT_DX [PCT_DOTS] = '{
    3'd0, 3'd1, 3'd0, 3'd1, 3'd4, 3'd5, 3'd4, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0
  };
  localparam logic [2:0] PCT_DY [PCT_DOTS] = '{
    3'd0, 3'd0, 3'd1, 3'd1, 3'd5, 3'd5, 3'd6, 3'd6, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5
  };

  // {valid, glyph index}; lower case folds onto upper case
  function automatic logic [6:0] glyph_lookup(input logic [7:0] code);
    logic [7:0] g;
    logic       ok;
    g  = 8'd0;
    ok = 1'b1;
    if (code >= 8'h30 && code <= 8'h39) begin
      g = code - 8'h30;
    end else if (code >= 8'h41 && code <= 8'h5a) begin
      g = code - 8'h41 + 8'd10;
    end else if (code >= 8'h61 && code <= 8'h7a) begin
      g = code - 8'h61 + 8'd10;
    end else if (code == 8'h20) begin
      g = 8'(SPACE_INDEX);
    end else begin
      ok = 1'b0;
    end
    return {ok, g[5:0]};
  endfunction

endpackage

@@ rtl/mfde_if.sv @@
// ----------------------------------------------------------------------------
// mfde_cmd_if / mfde_done_if
// Valid/ready channels for draw commands and completion results.
// ----------------------------------------------------------------------------
interface mfde_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic signed [8:0] pos_x;
  logic signed [8:0] pos_y;
  logic [7:0]        rect_width;
  logic [7:0]        rect_height;
  logic              pixel_on;
  logic [7:0]        glyph_code;
  logic [2:0]        glyph_scale;
  logic [5:0]        read_row;
  logic [3:0]        read_column;

  modport source (output valid, kind, pos_x, pos_y, rect_width, rect_height, pixel_on,
                  glyph_code, glyph_scale, read_row, read_column, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, rect_width, rect_height, pixel_on,
                  glyph_code, glyph_scale, read_row, read_column, output ready);
endinterface

interface mfde_done_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic [2:0] done_kind;

  modport source (output valid, read_byte, done_kind, input ready);
  modport sink   (input valid, read_byte, done_kind, output ready);
endinterface

@@ rtl/mfde_ram.sv @@
// ----------------------------------------------------------------------------
// mfde_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/mono_framebuffer_draw_engine_core.sv @@
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine_core
// 1 bpp framebuffer: plot, fill, 5x7 glyph, clear and byte read commands.
//
//   channel | dir | transfer
//   --------+-----+------------------------------------------
//   cmd     | in  | one draw / clear / read command
//   done    | out | read_byte and done_kind, one per command
//   cfg     | in  | mirror register write, no handshake
//
// Pixels are written by read-modify-write of whole bytes in the store RAM,
// through ST_BRD and ST_BWR for each touched byte, ST_ROW once per row and
// ST_RSETUP once per rectangle. Glyph: scan of the 5x7 font (a dot list for
// the percent sign) plus one rectangle per lit font pixel. Read: ST_RDWAIT.
// Clear: a sweep that zeroes all STORE_BYTES bytes of the store.
// After reset a sweep zeroes all STORE_BYTES (512) bytes of the store; no
// command is taken meanwhile. A held result stalls only command completion.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine_core
  import mfde_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mfde_cmd_if.sink    cmd,
  mfde_done_if.source done,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_data_i
);

  localparam logic [3:0] ST_INIT   = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_CLEAR  = 4'd2;
  localparam logic [3:0] ST_RDWAIT = 4'd3;
  localparam logic [3:0] ST_GLYPH  = 4'd4;
  localparam logic [3:0] ST_RSETUP = 4'd5;
  localparam logic [3:0] ST_ROW    = 4'd6;
  localparam logic [3:0] ST_BRD    = 4'd7;
  localparam logic [3:0] ST_BWR    = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  logic [3:0]           state_q, state_d;
  logic                 mh_q, mv_q;
  logic [AW-1:0]        clr_q, clr_d;
  logic [2:0]           kind_q, kind_d;
  logic [7:0]           rd_q, rd_d;
  logic                 dv_q, dv_d;
  logic [7:0]           drd_q, drd_d;
  logic [2:0]           dkind_q, dkind_d;
  // glyph walk
  logic                 pct_q, pct_d, from_glyph_q, from_glyph_d;
  logic signed [8:0]    gx_q, gx_d, gy_q, gy_d;
  logic [5:0]           g_q, g_d;
  logic [2:0]           scale_q, scale_d, gcol_q, gcol_d, grow_q, grow_d;
  logic [3:0]           pidx_q, pidx_d;
  // rectangle
  logic signed [CW-1:0] rx_q, rx_d, ry_q, ry_d;
  logic [7:0]           rw_q, rw_d, rh_q, rh_d;
  logic                 on_q, on_d;
  logic [XW-1:0]        lo_q, lo_d, hi_q, hi_d;
  logic [YW-1:0]        yy_q, yy_d, yend_q, yend_d, rowm_q, rowm_d;
  logic [BW-1:0]        b_q, b_d;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [7:0]           ram_wdata, ram_rdata;

  // rectangle clipping
  logic signed [CW-1:0] xe, ye, xl, xr, yl, yr;
  logic                 rect_empty;
  // byte mask
  logic [BW-1:0]        lo_b, hi_b;
  logic [2:0]           lo_bit, hi_bit;
  logic [7:0]           mask;
  logic [AW-1:0]        byte_addr;
  logic [6:0]           glu;
  logic                 font_bit;

  localparam logic signed [CW-1:0] XMAX = CW'(SCREEN_WIDTH - 1);
  localparam logic signed [CW-1:0] YMAX = CW'(SCREEN_HEIGHT - 1);

  mfde_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cmd.ready      = (state_q == ST_IDLE);
  assign done.valid     = dv_q;
  assign done.read_byte = drd_q;
  assign done.done_kind = dkind_q;

  assign xe = rx_q + CW'({1'b0, rw_q}) - CW'(1);
  assign ye = ry_q + CW'({1'b0, rh_q}) - CW'(1);
  assign xl = (rx_q < 0) ? '0 : rx_q;
  assign xr = (xe > XMAX) ? XMAX : xe;
  assign yl = (ry_q < 0) ? '0 : ry_q;
  assign yr = (ye > YMAX) ? YMAX : ye;
  assign rect_empty = (rw_q == 8'd0) || (rh_q == 8'd0) || (xl > xr) || (yl > yr);

  assign lo_b   = BW'(lo_q >> 3);
  assign hi_b   = BW'(hi_q >> 3);
  assign lo_bit = (b_q == lo_b) ? lo_q[2:0] : 3'd0;
  assign hi_bit = (b_q == hi_b) ? hi_q[2:0] : 3'd7;
  assign mask   = (8'hff >> lo_bit) & (8'hff << (3'd7 - hi_bit));

  assign byte_addr = AW'(32'(rowm_q) * ROW_BYTES + 32'(b_q));
  assign glu       = glyph_lookup(cmd.glyph_code);
  assign font_bit  = FONT_ROM[g_q][gcol_q][grow_q];

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    kind_d       = kind_q;
    rd_d         = rd_q;
    dv_d         = dv_q && !done.ready;
    drd_d        = drd_q;
    dkind_d      = dkind_q;
    pct_d        = pct_q;
    from_glyph_d = from_glyph_q;
    gx_d         = gx_q;
    gy_d         = gy_q;
    g_d          = g_q;
    scale_d      = scale_q;
    gcol_d       = gcol_q;
    grow_d       = grow_q;
    pidx_d       = pidx_q;
    rx_d         = rx_q;
    ry_d         = ry_q;
    rw_d         = rw_q;
    rh_d         = rh_q;
    on_d         = on_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    yy_d         = yy_q;
    yend_d       = yend_q;
    rowm_d       = rowm_q;
    b_d          = b_q;
    ram_we       = 1'b0;
    ram_waddr    = byte_addr;
    ram_wdata    = on_q ? (ram_rdata | mask) : (ram_rdata & ~mask);
    ram_raddr    = byte_addr;

    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 8'h00;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(STORE_BYTES - 1)) begin
          clr_d   = '0;
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        ram_raddr = AW'(32'(cmd.read_row) * ROW_BYTES + 32'(cmd.read_column));
        if (cmd.valid) begin
          kind_d       = cmd.kind;
          rd_d         = 8'h00;
          rx_d         = CW'(cmd.pos_x);
          ry_d         = CW'(cmd.pos_y);
          rw_d         = cmd.rect_width;
          rh_d         = cmd.rect_height;
          on_d         = cmd.pixel_on;
          gx_d         = cmd.pos_x;
          gy_d         = cmd.pos_y;
          g_d          = glu[5:0];
          scale_d      = cmd.glyph_scale;
          gcol_d       = 3'd0;
          grow_d       = 3'd0;
          pidx_d       = 4'd0;
          pct_d        = (cmd.glyph_code == CODE_PERCENT);
          from_glyph_d = 1'b0;
          state_d      = ST_DONE;
          priority case (cmd.kind)
            KIND_PLOT: begin
              rw_d    = 8'd1;
              rh_d    = 8'd1;
              state_d = ST_RSETUP;
            end
            KIND_FILL: state_d = ST_RSETUP;
            KIND_GLYPH: begin
              from_glyph_d = 1'b1;
              if (glu[6] || cmd.glyph_code == CODE_PERCENT) begin
                state_d = ST_GLYPH;
              end
            end
            KIND_CLEAR: state_d = ST_CLEAR;
            KIND_READ: begin
              if (32'(cmd.read_row) < SCREEN_HEIGHT && 32'(cmd.read_column) < ROW_BYTES) begin
                state_d = ST_RDWAIT;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_RDWAIT: begin
        rd_d    = ram_rdata;
        state_d = ST_DONE;
      end
      ST_GLYPH: begin
        on_d = 1'b1;
        if (pct_q) begin
          if (pidx_q == 4'(PCT_DOTS)) begin
            state_d = ST_DONE;
          end else begin
            rx_d    = CW'(gx_q) + CW'(PCT_DX[pidx_q]);
            ry_d    = CW'(gy_q) + CW'(PCT_DY[pidx_q]);
            rw_d    = 8'd1;
            rh_d    = 8'd1;
            pidx_d  = pidx_q + 4'd1;
            state_d = ST_RSETUP;
          end
        end else if (gcol_q == 3'd5) begin
          state_d = ST_DONE;
        end else begin
          rx_d = CW'(gx_q) + CW'(gcol_q) * CW'(scale_q);
          ry_d = CW'(gy_q) + CW'(grow_q) * CW'(scale_q);
          rw_d = {5'd0, scale_q};
          rh_d = {5'd0, scale_q};
          if (grow_q == 3'd6) begin
            grow_d = 3'd0;
            gcol_d = gcol_q + 3'd1;
          end else begin
            grow_d = grow_q + 3'd1;
          end
          if (font_bit && scale_q != 3'd0) begin
            state_d = ST_RSETUP;
          end
        end
      end
      ST_RSETUP: begin
        if (rect_empty) begin
          state_d = from_glyph_q ? ST_GLYPH : ST_DONE;
        end else begin
          lo_d    = mh_q ? (XW'(SCREEN_WIDTH - 1) - xr[XW-1:0]) : xl[XW-1:0];
          hi_d    = mh_q ? (XW'(SCREEN_WIDTH - 1) - xl[XW-1:0]) : xr[XW-1:0];
          yy_d    = yl[YW-1:0];
          yend_d  = yr[YW-1:0];
          state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        rowm_d  = mv_q ? (YW'(SCREEN_HEIGHT - 1) - yy_q) : yy_q;
        b_d     = lo_b;
        state_d = ST_BRD;
      end
      ST_BRD: begin
        state_d = ST_BWR;
      end
      ST_BWR: begin
        ram_we = 1'b1;
        if (b_q == hi_b) begin
          if (yy_q == yend_q) begin
            state_d = from_glyph_q ? ST_GLYPH : ST_DONE;
          end else begin
            yy_d    = yy_q + YW'(1);
            state_d = ST_ROW;
          end
        end else begin
          b_d     = b_q + BW'(1);
          state_d = ST_BRD;
        end
      end
      ST_DONE: begin
        if (!dv_q || done.ready) begin
          dv_d    = 1'b1;
          drd_d   = rd_q;
          dkind_d = kind_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      clr_q   <= '0;
      dv_q    <= 1'b0;
      mh_q    <= 1'b1;
      mv_q    <= 1'b1;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      dv_q    <= dv_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MIRROR_H: mh_q <= cfg_data_i;
          CFG_MIRROR_V: mv_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    rd_q         <= rd_d;
    drd_q        <= drd_d;
    dkind_q      <= dkind_d;
    pct_q        <= pct_d;
    from_glyph_q <= from_glyph_d;
    gx_q         <= gx_d;
    gy_q         <= gy_d;
    g_q          <= g_d;
    scale_q      <= scale_d;
    gcol_q       <= gcol_d;
    grow_q       <= grow_d;
    pidx_q       <= pidx_d;
    rx_q         <= rx_d;
    ry_q         <= ry_d;
    rw_q         <= rw_d;
    rh_q         <= rh_d;
    on_q         <= on_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    yy_q         <= yy_d;
    yend_q       <= yend_d;
    rowm_q       <= rowm_d;
    b_q          <= b_d;
  end

endmodule
